/* hdl/acpi_s5_sleep_type_scanner_unit_assert.svh */
// Assertion macros for the S5 sleep type scanner.
// Included by the top level; no other dependencies.
`ifndef ACPI_S5_SLEEP_TYPE_SCANNER_UNIT_ASSERT_SVH
`define ACPI_S5_SLEEP_TYPE_SCANNER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define S5SCAN_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s5scan assertion failed");
`define S5SCAN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s5scan assertion failed");
`else
`define S5SCAN_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define S5SCAN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/s5scan_pkg.sv */
// Shared constants, types and helpers for the S5 sleep type scanner.
// No dependencies.
package s5scan_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;

  localparam logic [31:0] S5_NAME     = 32'h5F53_355F;
  localparam logic [7:0]  PKG_OP      = 8'h12;
  localparam logic [7:0]  BYTE_PREFIX = 8'h0A;

  localparam int TYPE_BITS = 3;
  localparam int CTL_BITS  = 16;

  localparam int PHASE_BITS = 4;
  localparam logic [PHASE_BITS-1:0] PH_SEARCH   = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_PKGLEN   = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_SKIP     = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_COUNT    = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_TYPA     = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_TYPA_VAL = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_TYPB     = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_TYPB_VAL = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_DONE     = 4'd8;

  typedef struct packed {
    logic sig_hit;
  } hdr_status_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [TYPE_BITS-1:0] type_a;
    logic [TYPE_BITS-1:0] type_b;
  } result_t;

  // PM1 control word: SLP_TYP in bits 12:10, SLP_EN in bit 13.
  function automatic logic [CTL_BITS-1:0] ctl_word(input logic ok,
                                                   input logic [TYPE_BITS-1:0] typ);
    logic [CTL_BITS-1:0] w;
    w = {2'b00, 1'b1, typ, 10'b0};
    return ok ? w : '0;
  endfunction

endpackage

/* hdl/s5scan_hdr_track.sv */
// Byte offset, table length capture and four-byte name window.
// Depends on s5scan_pkg.
module s5scan_hdr_track #(
  parameter int LENGTH_BITS = s5scan_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic [7:0]                data_byte,
  input  logic                      last,
  output s5scan_pkg::hdr_status_t   status
);

  logic [31:0]            byte_offset;
  logic [LENGTH_BITS-1:0] table_length;
  logic [31:0]            recent_bytes;

  logic                   len_window;
  logic [31:0]            lane;
  logic [LENGTH_BITS-1:0] length_cur;
  logic                   len_ok;
  logic                   start_ok;
  logic                   past_header;

  always_comb begin
    past_header = byte_offset >= 32'd4;
    len_window  = past_header && (byte_offset < 32'd8);
    lane        = 32'(data_byte) << {byte_offset[1:0], 3'b000};
    length_cur  = len_window ? (table_length | lane[LENGTH_BITS-1:0]) : table_length;
    len_ok      = length_cur >= LENGTH_BITS'(8);
    // name start (offset - 4) below length - 8  <=>  offset + 4 below length
    start_ok    = ({1'b0, byte_offset} + 33'd4) < 33'(length_cur);
    status.sig_hit = past_header && (recent_bytes == s5scan_pkg::S5_NAME) &&
                     (data_byte == s5scan_pkg::PKG_OP) && len_ok && start_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset  <= '0;
      table_length <= '0;
      recent_bytes <= '0;
    end else if (fire) begin
      if (last) begin
        byte_offset  <= '0;
        table_length <= '0;
        recent_bytes <= '0;
      end else begin
        if (byte_offset != '1) begin
          byte_offset <= byte_offset + 32'd1;
        end
        table_length <= length_cur;
        recent_bytes <= {recent_bytes[23:0], data_byte};
      end
    end
  end

endmodule

/* hdl/s5scan_pkg_parse.sv */
// Parse state machine for the _S5_ package body: length skip, count, two types.
// Depends on s5scan_pkg.
module s5scan_pkg_parse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [7:0]               data_byte,
  input  logic                     last,
  input  s5scan_pkg::hdr_status_t  status,
  output s5scan_pkg::result_t      result
);

  logic [s5scan_pkg::PHASE_BITS-1:0] parse_phase;
  logic [s5scan_pkg::PHASE_BITS-1:0] parse_phase_next;
  logic [1:0]                        skip_left;
  logic [1:0]                        skip_left_next;
  logic [s5scan_pkg::TYPE_BITS-1:0]  held_type_a;
  logic [s5scan_pkg::TYPE_BITS-1:0]  held_type_a_next;
  logic                              emit_found;
  logic                              is_prefix;

  always_comb begin
    parse_phase_next = parse_phase;
    skip_left_next   = skip_left;
    held_type_a_next = held_type_a;
    emit_found       = 1'b0;
    is_prefix        = data_byte == s5scan_pkg::BYTE_PREFIX;

    unique case (parse_phase)
      s5scan_pkg::PH_SEARCH: begin
        if (status.sig_hit) begin
          parse_phase_next = s5scan_pkg::PH_PKGLEN;
        end
      end
      s5scan_pkg::PH_PKGLEN: begin
        skip_left_next   = data_byte[7:6];
        parse_phase_next = (data_byte[7:6] != 2'd0) ? s5scan_pkg::PH_SKIP
                                                    : s5scan_pkg::PH_COUNT;
      end
      s5scan_pkg::PH_SKIP: begin
        skip_left_next = skip_left - 2'd1;
        if (skip_left == 2'd1) begin
          parse_phase_next = s5scan_pkg::PH_COUNT;
        end
      end
      s5scan_pkg::PH_COUNT: begin
        parse_phase_next = s5scan_pkg::PH_TYPA;
      end
      s5scan_pkg::PH_TYPA: begin
        if (is_prefix) begin
          parse_phase_next = s5scan_pkg::PH_TYPA_VAL;
        end else begin
          held_type_a_next = data_byte[2:0];
          parse_phase_next = s5scan_pkg::PH_TYPB;
        end
      end
      s5scan_pkg::PH_TYPA_VAL: begin
        held_type_a_next = data_byte[2:0];
        parse_phase_next = s5scan_pkg::PH_TYPB;
      end
      s5scan_pkg::PH_TYPB: begin
        if (is_prefix) begin
          parse_phase_next = s5scan_pkg::PH_TYPB_VAL;
        end else begin
          emit_found       = 1'b1;
          parse_phase_next = s5scan_pkg::PH_DONE;
        end
      end
      s5scan_pkg::PH_TYPB_VAL: begin
        emit_found       = 1'b1;
        parse_phase_next = s5scan_pkg::PH_DONE;
      end
      default: begin
        parse_phase_next = s5scan_pkg::PH_DONE;
      end
    endcase

    result.found  = emit_found;
    result.type_a = emit_found ? held_type_a : '0;
    result.type_b = emit_found ? data_byte[2:0] : '0;
    // not-found only if this table has not reported yet
    result.valid  = emit_found || (last && (parse_phase != s5scan_pkg::PH_DONE));

    if (last) begin
      parse_phase_next = s5scan_pkg::PH_SEARCH;
      skip_left_next   = '0;
      held_type_a_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= s5scan_pkg::PH_SEARCH;
      skip_left   <= '0;
      held_type_a <= '0;
    end else if (fire) begin
      parse_phase <= parse_phase_next;
      skip_left   <= skip_left_next;
      held_type_a <= held_type_a_next;
    end
  end

endmodule

/* hdl/acpi_s5_sleep_type_scanner_unit.sv */
// Top level of the S5 sleep type scanner: input register, header tracker,
// package parser and result register. Depends on s5scan_pkg, s5scan_hdr_track,
// s5scan_pkg_parse and acpi_s5_sleep_type_scanner_unit_assert.svh.
//
// Usage: stream the DSDT bytes in order on data_byte with data_valid, one per
// transaction, and raise last on the final byte. A transaction completes when
// valid is high and stall is low. Each table yields exactly one result:
// found = 1 with both SLP_TYP values and the PM1a/PM1b control words once the
// _S5_ package is parsed, or found = 0 with all fields zero on the last byte
// when no package was found. Bytes after a result are consumed silently.
// A byte waits in the input register; its result loads the result register when it fires.
// Throughput: one byte per cycle while data_stall is low; the per-byte work is a window
// compare, a length add/compare and a small state update between the two registers.
// Reset clears all tracking state; the block then waits for a table header.
// When result_stall holds, the finished result waits in the result register
// while one more byte is held in the input register; data_stall rises only
// when both are full.
`include "acpi_s5_sleep_type_scanner_unit_assert.svh"
module acpi_s5_sleep_type_scanner_unit #(
  parameter int LENGTH_BITS = s5scan_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 data_valid,
  output logic                                 data_stall,
  input  logic [7:0]                           data_byte,
  input  logic                                 last,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 found,
  output logic [s5scan_pkg::TYPE_BITS-1:0]     sleep_type_a,
  output logic [s5scan_pkg::TYPE_BITS-1:0]     sleep_type_b,
  output logic [s5scan_pkg::CTL_BITS-1:0]      control_word_a,
  output logic [s5scan_pkg::CTL_BITS-1:0]      control_word_b
);

  logic                     in_full;
  logic [7:0]               in_byte;
  logic                     in_last;
  logic                     advance;
  logic                     fire;
  logic                     accept;
  s5scan_pkg::hdr_status_t  status;
  s5scan_pkg::result_t      result;

  assign advance    = !result_valid || !result_stall;
  assign fire       = in_full && advance;
  assign data_stall = in_full && !advance;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_last <= last;
    end
  end

  s5scan_hdr_track #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_hdr (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .last      (in_last),
    .status    (status)
  );

  s5scan_pkg_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .last      (in_last),
    .status    (status),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= fire && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && result.valid && advance) begin
      found          <= result.found;
      sleep_type_a   <= result.type_a;
      sleep_type_b   <= result.type_b;
      control_word_a <= s5scan_pkg::ctl_word(result.found, result.type_a);
      control_word_b <= s5scan_pkg::ctl_word(result.found, result.type_b);
    end
  end

  `S5SCAN_ASSERT_IMPLY(a_ctl_match, clk, rst, result_valid && found, (control_word_a == s5scan_pkg::ctl_word(1'b1, sleep_type_a)) && (control_word_b == s5scan_pkg::ctl_word(1'b1, sleep_type_b)))
  `S5SCAN_ASSERT_IMPLY(a_notfound_zero, clk, rst, result_valid && !found, (sleep_type_a == '0) && (sleep_type_b == '0) && (control_word_a == '0) && (control_word_b == '0))
  `S5SCAN_ASSERT_IMPLY(a_stall_only_full, clk, rst, data_stall, in_full && result_valid && result_stall)
  `S5SCAN_ASSERT_NEXT(a_result_loads, clk, rst, fire && result.valid, result_valid)

endmodule

/* tb/sv/tb_acpi_s5_sleep_type_scanner_unit.sv */
// Self-checking testbench for the S5 sleep type scanner: streams directed and random
// DSDT-like tables, predicts each table's result in a scoreboard class and compares.
// Depends on s5scan_pkg and acpi_s5_sleep_type_scanner_unit.
module tb_acpi_s5_sleep_type_scanner_unit;

  localparam int LEN_BITS = s5scan_pkg::LENGTH_BITS_DEFAULT;
  localparam bit [31:0] LEN_MASK = 32'((64'd1 << LEN_BITS) - 1);
  localparam bit [15:0] SLEEP_ENABLE = 16'h2000;
  localparam int RANDOM_BYTES = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        found;
    logic [2:0]  type_a;
    logic [2:0]  type_b;
    logic [15:0] ctl_a;
    logic [15:0] ctl_b;
  } sleep_result_t;

  class s5_result_checker;
    bit [31:0] offset;
    bit [31:0] tbl_len;
    bit [31:0] window;
    bit [s5scan_pkg::PHASE_BITS-1:0] phase;
    bit [1:0] skip_cnt;
    bit [2:0] held_a;
    bit reported;
    sleep_result_t expected_q[$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      offset = 0;
      tbl_len = 0;
      window = 0;
      phase = s5scan_pkg::PH_SEARCH;
      skip_cnt = 0;
      held_a = 0;
      reported = 0;
    endfunction

    function sleep_result_t make_result(bit ok, bit [2:0] ta, bit [2:0] tb);
      sleep_result_t r;
      r.found = ok;
      r.type_a = ok ? ta : 3'd0;
      r.type_b = ok ? tb : 3'd0;
      r.ctl_a = ok ? ((16'(ta) << 10) | SLEEP_ENABLE) : 16'd0;
      r.ctl_b = ok ? ((16'(tb) << 10) | SLEEP_ENABLE) : 16'd0;
      return r;
    endfunction

    // Accepted input transaction: advance the parse and queue any result it causes.
    function void take_byte(bit [7:0] b, bit is_last);
      bit [31:0] off;
      bit emitted;
      off = offset;
      emitted = 0;
      if (off >= 4 && off <= 7)
        tbl_len = (tbl_len | (32'(b) << (8 * (off - 4)))) & LEN_MASK;
      case (phase)
        s5scan_pkg::PH_SEARCH: begin
          if (off >= 4 && window == s5scan_pkg::S5_NAME && b == s5scan_pkg::PKG_OP &&
              tbl_len >= 8 && (off - 4) < (tbl_len - 8))
            phase = s5scan_pkg::PH_PKGLEN;
        end
        s5scan_pkg::PH_PKGLEN: begin
          skip_cnt = b[7:6];
          phase = (skip_cnt != 0) ? s5scan_pkg::PH_SKIP : s5scan_pkg::PH_COUNT;
        end
        s5scan_pkg::PH_SKIP: begin
          skip_cnt = skip_cnt - 1;
          if (skip_cnt == 0) phase = s5scan_pkg::PH_COUNT;
        end
        s5scan_pkg::PH_COUNT: phase = s5scan_pkg::PH_TYPA;
        s5scan_pkg::PH_TYPA, s5scan_pkg::PH_TYPA_VAL: begin
          if (phase == s5scan_pkg::PH_TYPA && b == s5scan_pkg::BYTE_PREFIX) begin
            phase = s5scan_pkg::PH_TYPA_VAL;
          end else begin
            held_a = b[2:0];
            phase = s5scan_pkg::PH_TYPB;
          end
        end
        s5scan_pkg::PH_TYPB, s5scan_pkg::PH_TYPB_VAL: begin
          if (phase == s5scan_pkg::PH_TYPB && b == s5scan_pkg::BYTE_PREFIX) begin
            phase = s5scan_pkg::PH_TYPB_VAL;
          end else begin
            expected_q.push_back(make_result(1'b1, held_a, b[2:0]));
            emitted = 1;
            reported = 1;
            phase = s5scan_pkg::PH_DONE;
          end
        end
        default: phase = s5scan_pkg::PH_DONE;
      endcase
      window = {window[23:0], b};
      if (offset != 32'hFFFF_FFFF) offset++;
      if (is_last) begin
        if (!emitted && !reported) expected_q.push_back(make_result(1'b0, 3'd0, 3'd0));
        restart();
      end
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(sleep_result_t got);
      sleep_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b a=%0d b=%0d",
                 $time, got.found, got.type_a, got.type_b);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("found", 16'(exp.found), 16'(got.found));
      compare_field("sleep_type_a", 16'(exp.type_a), 16'(got.type_a));
      compare_field("sleep_type_b", 16'(exp.type_b), 16'(got.type_b));
      compare_field("control_word_a", exp.ctl_a, got.ctl_a);
      compare_field("control_word_b", exp.ctl_b, got.ctl_b);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        data_valid;
  logic        data_stall;
  logic [7:0]  data_byte;
  logic        last;
  logic        result_valid;
  logic        result_stall;
  logic        found;
  logic [2:0]  sleep_type_a;
  logic [2:0]  sleep_type_b;
  logic [15:0] control_word_a;
  logic [15:0] control_word_b;

  s5_result_checker scan_sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int cycle_cnt = 0;

  acpi_s5_sleep_type_scanner_unit #(.LENGTH_BITS(LEN_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .last(last),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .found(found),
    .sleep_type_a(sleep_type_a),
    .sleep_type_b(sleep_type_b),
    .control_word_a(control_word_a),
    .control_word_b(control_word_b)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      scan_sb.check_result('{found, sleep_type_a, sleep_type_b, control_word_a,
                             control_word_b});
  end

  task automatic send_byte(bit [7:0] b, bit is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    last <= is_last;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    scan_sb.take_byte(b, is_last);
    bytes_sent++;
  endtask

  // Writes the name, package opcode, package length, count and both types from p on;
  // anything past the end of the table is dropped, leaving a truncated package.
  task automatic place_package(ref bit [7:0] tbl[], input int p);
    bit [7:0] seq[$];
    bit [7:0] lead;
    int i;
    seq = '{8'h5F, 8'h53, 8'h35, 8'h5F, s5scan_pkg::PKG_OP};
    lead = $urandom_range(0, 255);
    seq.push_back(lead);
    for (i = 0; i < lead[7:6]; i++) seq.push_back($urandom_range(0, 255));
    seq.push_back($urandom_range(0, 255));
    for (i = 0; i < 2; i++) begin
      if ($urandom_range(0, 1)) seq.push_back(s5scan_pkg::BYTE_PREFIX);
      seq.push_back($urandom_range(0, 255));
    end
    foreach (seq[k]) if (p + k < tbl.size()) tbl[p + k] = seq[k];
  endtask

  task automatic send_table();
    bit [7:0] tbl[];
    bit [31:0] len_field;
    int total;
    int r;
    int p;
    total = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 260) : $urandom_range(1, 48);
    tbl = new[total];
    foreach (tbl[i]) tbl[i] = $urandom_range(0, 255);
    r = $urandom_range(0, 9);
    if (r == 0) len_field = $urandom_range(0, 7);
    else if (r == 1) len_field = $urandom();
    else len_field = 32'(total + $urandom_range(0, 6) - 3);
    for (int k = 0; k < 4; k++) if (4 + k < total) tbl[4 + k] = len_field[8*k +: 8];
    if ($urandom_range(0, 9) < 8) begin
      // early names overlap the length field
      p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, total - 1);
      place_package(tbl, p);
      if ($urandom_range(0, 3) == 0) place_package(tbl, $urandom_range(p, total - 1));
    end
    foreach (tbl[i]) send_byte(tbl[i], i == total - 1);
  endtask

  initial begin
    bit [7:0] demo[22];
    int ph;
    demo = '{8'h44, 8'h53, 8'h44, 8'h54, 8'd22, 8'h00, 8'h00, 8'h00,
             8'h5F, 8'h53, 8'h35, 8'h5F, s5scan_pkg::PKG_OP, 8'hC0, 8'h01, 8'h02,
             8'h03, 8'h02, s5scan_pkg::BYTE_PREFIX, 8'hFF, s5scan_pkg::BYTE_PREFIX,
             8'h00};
    scan_sb = new();
    rst <= 1'b1;
    data_valid <= 1'b0;
    data_byte <= 8'h00;
    last <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // one-byte table, then a full package with maximum skip ending on its last byte
    send_byte(8'hFF, 1'b1);
    foreach (demo[i]) send_byte(demo[i], i == 21);

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      ph = (bytes_sent * 4) / RANDOM_BYTES;
      idle_pct = (ph == 1) ? 73 : (ph == 3) ? 35 : 0;
      stall_pct = (ph == 2) ? 73 : (ph == 3) ? 35 : 0;
      send_table();
    end
    data_valid <= 1'b0;

    while (scan_sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (scan_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
